[sv/sbma_pkg.sv]
// Shared types and codes of the sized byte memory access block.
`default_nettype none

package sbma_pkg;

    localparam logic       CMD_READ  = 1'b0;
    localparam logic       CMD_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam int         SIZE_REG_W     = 17;
    localparam logic [16:0] SIZE_REG_RESET = 17'h10000;

    typedef struct packed {
        logic        command;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        out_of_range;
    } out_item_t;

    typedef struct packed {
        logic [1:0] size;
        logic [1:0] lane;
        logic       piece;
    } lane_ctrl_t;

endpackage

`default_nettype wire

[sv/sbma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sbma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/sbma_lane_unit.sv]
// Shared byte-lane shift unit: extracts a read value and merges write data into a word.
`default_nettype none

module sbma_lane_unit (
    input  wire sbma_pkg::lane_ctrl_t ctrl,
    input  wire logic [31:0]          word,
    input  wire logic [31:0]          data,
    output logic      [31:0]          merged,
    output logic      [31:0]          rval
);

    logic [4:0]  sh;
    logic [31:0] wm;
    logic [31:0] d;

    always_comb
    begin
        unique case (ctrl.size)
            sbma_pkg::SIZE_BYTE:
            begin
                wm = 32'h0000_00ff;
                sh = ctrl.piece ? 5'd0 : {ctrl.lane, 3'b000};
            end
            sbma_pkg::SIZE_HALF:
            begin
                wm = ctrl.piece ? 32'h0000_00ff : 32'h0000_ffff;
                sh = ctrl.piece ? 5'd0 : {ctrl.lane, 3'b000};
            end
            default:
            begin
                wm = 32'hffff_ffff;
                sh = 5'd0;
            end
        endcase
        d      = ctrl.piece ? {8'd0, data[31:8]} : data;
        merged = (word & ~(wm << sh)) | ((d & wm) << sh);
        rval   = ctrl.piece ? ((word & wm) << 8) : ((word >> sh) & wm);
    end

endmodule

`default_nettype wire

[sv/sized_byte_memory_access.sv]
// Top level of the sized byte memory access block: sequencer, size register and store.
//
// Input items arrive on in_valid/in_stall with an in_item payload; each is one
// byte, halfword or word read or write. Results leave on out_valid/out_stall
// with an out_item payload, one per input item, in order.
// The store size register is written on cfg_valid/cfg_ready; cfg_ready is
// always high and writes are meant to happen while the block is idle.
// After reset the store is swept to zero, one word per cycle; in_stall stays
// high during that pass.
// A sequencer drives one shared lane shift unit and the RAM's read and write ports.
// Each item passes a check state, one read step per word visited and a done
// state that loads the output register. Out-of-range items skip the reads; a
// halfword spanning two words visits both. The next item is accepted once the
// sequencer is idle again. Each word visited costs one registered RAM read.
// When the receiver stalls, the result waits in the output register and the
// block still takes the next item; that item's result waits until the
// register is free.
`default_nettype none

module sized_byte_memory_access #(
    parameter int STORE_WORDS = 65536
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire sbma_pkg::in_item_t   in_item,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output sbma_pkg::out_item_t       out_item,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [16:0]          cfg_data
);

    localparam int          AW        = $clog2(STORE_WORDS);
    localparam logic [31:0] STORE_LIM = 32'(STORE_WORDS);
    localparam logic [AW-1:0] LAST_WORD = AW'(STORE_WORDS - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CHECK = 6'b000100,
        S_RD0   = 6'b001000,
        S_RD1   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [16:0]         size_reg;
    sbma_pkg::in_item_t  item_reg;
    logic [31:0]         rd_reg, rd_next;
    logic                oor_reg, oor_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                out_valid_reg, out_valid_next;
    sbma_pkg::out_item_t out_item_reg;
    logic                out_load;

    logic [30:0]         off;
    logic [28:0]         idx;
    logic [1:0]          lane;
    logic [31:0]         lim_raw, lim, idx_ext;
    logic                span, oor, is_write, accept;
    logic [AW-1:0]       idx_lo, idx_p1;

    sbma_pkg::lane_ctrl_t lctrl;
    logic [31:0]         merged, rval;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [31:0]         ram_wdata, ram_rdata;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        off      = item_reg.address[31] ? item_reg.address[30:0]
                                        : {4'd0, item_reg.address[26:0]};
        idx      = off[30:2];
        lane     = off[1:0];
        lim_raw  = (size_reg == '0) ? 32'd1 : {15'd0, size_reg};
        lim      = (lim_raw > STORE_LIM) ? STORE_LIM : lim_raw;
        idx_ext  = {3'd0, idx};
        span     = (item_reg.access_size == sbma_pkg::SIZE_HALF) && (lane == 2'd3);
        oor      = (idx_ext >= lim) || (span && ((idx_ext + 32'd1) >= lim));
        is_write = (item_reg.command == sbma_pkg::CMD_WRITE);
        idx_lo   = idx[AW-1:0];
        idx_p1   = idx_lo + AW'(1);
    end

    assign lctrl.size  = item_reg.access_size;
    assign lctrl.lane  = lane;
    assign lctrl.piece = (state_reg == S_RD1);

    sbma_lane_unit u_lane (
        .ctrl   (lctrl),
        .word   (ram_rdata),
        .data   (item_reg.write_data),
        .merged (merged),
        .rval   (rval)
    );

    sbma_ram #(
        .WIDTH (32),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        rd_next        = rd_reg;
        oor_next       = oor_reg;
        clr_next       = clr_reg;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = idx_lo;
        ram_wdata      = merged;
        ram_re         = 1'b0;
        ram_raddr      = idx_lo;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                rd_next    = '0;
                oor_next   = oor;
                ram_re     = !oor;
                state_next = oor ? S_DONE : S_RD0;
            end
            S_RD0:
            begin
                ram_we = is_write;
                if (!is_write)
                begin
                    rd_next = rd_reg | rval;
                end
                if (span)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_p1;
                    state_next = S_RD1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RD1:
            begin
                ram_we    = is_write;
                ram_waddr = idx_p1;
                if (!is_write)
                begin
                    rd_next = rd_reg | rval;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            size_reg      <= sbma_pkg::SIZE_REG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg  <= rd_next;
        oor_reg <= oor_next;
        if (accept)
        begin
            item_reg <= in_item;
        end
        if (out_load)
        begin
            out_item_reg.read_data    <= rd_reg;
            out_item_reg.out_of_range <= oor_reg;
        end
    end

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared without a finished access");

    a_rd1_after_rd0: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD1) |-> $past(state_reg == S_RD0))
        else $error("second word visited out of order");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_CLEAR) || (state_reg == S_RD0) || (state_reg == S_RD1)))
        else $error("store written outside a write step");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.out_of_range) |-> (out_item_reg.read_data == 32'd0))
        else $error("out-of-range item returned data");

    a_no_load_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(out_item_reg))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire
